// ===== hw/rtl/afpda_pkg.sv =====
package afpda_pkg;

  typedef enum logic [0:0] {
    OP_ACCUM  = 1'b0,
    OP_FINISH = 1'b1
  } op_e;

  // source formats
  localparam int FP16_FRAC     = 10;
  localparam int FP16_EXP_BIAS = 15;
  localparam int E4M3_FRAC     = 3;
  localparam int E4M3_EXP_BIAS = 7;
  localparam int SIG_W         = 11;

  // signed width of shift and exponent arithmetic
  localparam int SHIFT_W = 11;

  // bf16 result format
  localparam int          BF16_BIAS    = 127;
  localparam int          BF16_EXP_MAX = 255;
  localparam int          BF16_MANT_W  = 7;
  localparam logic [15:0] BF16_INF     = 16'h7F80;

  // request queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = 3;

endpackage

// ===== hw/rtl/afpda_front.sv =====
module afpda_front #(
  parameter int SUM_WIDTH = 32
) (
  input  logic                 in_valid_i,
  input  logic                 opcode_i,
  input  logic [15:0]          operand_bits_i,
  input  logic [7:0]           anchor_exponent_i,
  output logic                 in_stall_o,
  input  logic                 q_full_i,
  output logic                 push_o,
  output afpda_pkg::op_e       push_op_o,
  output logic [SUM_WIDTH-1:0] push_value_o,
  output logic [7:0]           push_anchor_o
);

  localparam int SHW = afpda_pkg::SHIFT_W;
  localparam int SAW = $clog2(SUM_WIDTH);
  localparam int SGW = afpda_pkg::SIG_W;

  localparam logic signed [SHW-1:0] K_FP16 =
    SHW'(afpda_pkg::FP16_FRAC + afpda_pkg::FP16_EXP_BIAS - (SUM_WIDTH - 1));
  localparam logic signed [SHW-1:0] K_E4M3 =
    SHW'(afpda_pkg::E4M3_FRAC + afpda_pkg::E4M3_EXP_BIAS - (SUM_WIDTH - 1));
  localparam logic signed [SHW-1:0] SH_HI = SHW'(SUM_WIDTH);
  localparam logic signed [SHW-1:0] SH_LO = SHW'(1 - SUM_WIDTH);

  afpda_pkg::op_e         op;
  logic                   sgn;
  logic [4:0]             expf;
  logic [4:0]             exp_eff;
  logic                   nonzero;
  logic [SGW-1:0]         sig;
  logic signed [SHW-1:0]  k_off;
  logic signed [SHW-1:0]  shr;
  logic signed [SHW-1:0]  shl;
  logic [SUM_WIDTH-1:0]   ext;
  logic [SUM_WIDTH-1:0]   mag;

  assign op         = afpda_pkg::op_e'(opcode_i);
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    case (op)
      afpda_pkg::OP_ACCUM: begin
        sgn     = operand_bits_i[15];
        expf    = operand_bits_i[14:10];
        nonzero = (operand_bits_i[14:0] != 15'd0);
        sig     = {(operand_bits_i[14:10] != 5'd0), operand_bits_i[9:0]};
        k_off   = K_FP16;
      end
      afpda_pkg::OP_FINISH: begin
        sgn     = operand_bits_i[7];
        expf    = {1'b0, operand_bits_i[6:3]};
        nonzero = (operand_bits_i[6:0] != 7'd0);
        sig     = {7'd0, (operand_bits_i[6:3] != 4'd0), operand_bits_i[2:0]};
        k_off   = K_E4M3;
      end
      default: begin
        sgn     = 1'b0;
        expf    = 5'd0;
        nonzero = 1'b0;
        sig     = '0;
        k_off   = '0;
      end
    endcase
    // subnormals take the minimum exponent
    exp_eff = (expf == 5'd0) ? 5'd1 : expf;
    shr = $signed({{(SHW-8){1'b0}}, anchor_exponent_i}) + k_off
        - $signed({{(SHW-5){1'b0}}, exp_eff});
    shl = -shr;
    ext = {{(SUM_WIDTH-SGW){1'b0}}, sig};
    if (!nonzero || shr >= SH_HI || shr < SH_LO) begin
      mag = '0;
    end else if (shr >= 0) begin
      mag = ext >> shr[SAW-1:0];
    end else begin
      mag = ext << shl[SAW-1:0];
    end
    push_value_o = sgn ? (~mag + 1'b1) : mag;
  end

  assign push_op_o     = op;
  assign push_anchor_o = anchor_exponent_i;

endmodule

// ===== hw/rtl/afpda_queue.sv =====
module afpda_queue #(
  parameter int SUM_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  afpda_pkg::op_e       push_op_i,
  input  logic [SUM_WIDTH-1:0] push_value_i,
  input  logic [7:0]           push_anchor_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output afpda_pkg::op_e       head_op_o,
  output logic [SUM_WIDTH-1:0] head_value_o,
  output logic [7:0]           head_anchor_o
);

  localparam int DEPTH = afpda_pkg::QUEUE_DEPTH;
  localparam int PW    = afpda_pkg::QUEUE_PTR_W;
  localparam int CW    = afpda_pkg::QUEUE_CNT_W;

  afpda_pkg::op_e       op_q    [DEPTH];
  logic [SUM_WIDTH-1:0] value_q [DEPTH];
  logic [7:0]           anchor_q[DEPTH];

  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  assign head_op_o     = op_q[rd_ptr_q];
  assign head_value_o  = value_q[rd_ptr_q];
  assign head_anchor_o = anchor_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      op_q[wr_ptr_q]     <= push_op_i;
      value_q[wr_ptr_q]  <= push_value_i;
      anchor_q[wr_ptr_q] <= push_anchor_i;
    end
  end

endmodule

// ===== hw/rtl/afpda_back.sv =====
module afpda_back #(
  parameter int SUM_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  afpda_pkg::op_e       q_op_i,
  input  logic [SUM_WIDTH-1:0] q_value_i,
  input  logic [7:0]           q_anchor_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [15:0]          bf16_result_o
);

  localparam int SHW = afpda_pkg::SHIFT_W;
  localparam int SAW = $clog2(SUM_WIDTH);
  localparam int MW  = afpda_pkg::BF16_MANT_W;

  localparam logic signed [SHW-1:0] EXP_OFF =
    SHW'(afpda_pkg::BF16_BIAS - (SUM_WIDTH - 1));
  localparam logic signed [SHW-1:0] EXP_MAX = SHW'(afpda_pkg::BF16_EXP_MAX);
  localparam logic [SAW-1:0]        TOP_POS = SAW'(SUM_WIDTH - 1);

  logic adv;
  logic finish;

  // running sum
  logic [SUM_WIDTH-1:0] sum_q, sum_d;
  logic [SUM_WIDTH-1:0] total;

  // stage 1: finished sum
  logic                 s1_valid_q, s1_valid_d;
  logic [SUM_WIDTH-1:0] s1_sum_q;
  logic [7:0]           s1_anchor_q;

  // stage 2: sign, magnitude, leading bit
  logic                 s2_valid_q, s2_valid_d;
  logic                 s2_sgn_q;
  logic                 s2_zero_q;
  logic [SUM_WIDTH-1:0] s2_mag_q;
  logic [SAW-1:0]       s2_msb_q;
  logic [7:0]           s2_anchor_q;

  logic                 sgn_c;
  logic [SUM_WIDTH-1:0] mag_c;
  logic [SAW-1:0]       msb_c;

  // stage 3: normalize and round
  logic signed [SHW-1:0] bexp;
  logic signed [SHW-1:0] bexp_r;
  logic [SUM_WIDTH-1:0]  norm;
  logic [MW-1:0]         mant;
  logic [MW:0]           mant_r;
  logic                  guard;
  logic                  sticky;
  logic                  round_up;
  logic [15:0]           result_c;

  logic        out_valid_q, out_valid_d;
  logic [15:0] result_q;

  // the whole back end moves only when the output slot frees up
  assign adv    = !out_valid_q || !out_stall_i;
  assign pop_o  = q_valid_i && adv;
  assign finish = (q_op_i == afpda_pkg::OP_FINISH);
  assign total  = sum_q + q_value_i;

  always_comb begin
    sum_d = sum_q;
    if (pop_o) begin
      sum_d = finish ? '0 : total;
    end
    s1_valid_d  = adv ? (pop_o && finish) : s1_valid_q;
    s2_valid_d  = adv ? s1_valid_q : s2_valid_q;
    out_valid_d = adv ? s2_valid_q : out_valid_q;
  end

  // most negative sum negates to itself, which reads as the top magnitude
  always_comb begin
    sgn_c = s1_sum_q[SUM_WIDTH-1];
    mag_c = sgn_c ? (~s1_sum_q + 1'b1) : s1_sum_q;
    msb_c = '0;
    for (int i = 0; i < SUM_WIDTH; i++) begin
      if (mag_c[i]) begin
        msb_c = SAW'(i);
      end
    end
  end

  always_comb begin
    bexp = $signed({{(SHW-SAW){1'b0}}, s2_msb_q})
         + $signed({{(SHW-8){1'b0}}, s2_anchor_q}) + EXP_OFF;
    norm     = s2_mag_q << (TOP_POS - s2_msb_q);
    mant     = norm[SUM_WIDTH-2 -: MW];
    guard    = norm[SUM_WIDTH-2-MW];
    sticky   = |norm[SUM_WIDTH-3-MW:0];
    round_up = guard && (sticky || mant[0]);
    mant_r   = {1'b0, mant} + {{MW{1'b0}}, round_up};
    bexp_r   = bexp + $signed({{(SHW-1){1'b0}}, mant_r[MW]});
    if (s2_zero_q) begin
      result_c = 16'h0000;
    end else if (bexp <= 0) begin
      result_c = {s2_sgn_q, 15'd0};
    end else if (bexp_r >= EXP_MAX) begin
      result_c = {s2_sgn_q, afpda_pkg::BF16_INF[14:0]};
    end else begin
      result_c = {s2_sgn_q, bexp_r[7:0], mant_r[MW-1:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && finish) begin
      s1_sum_q    <= total;
      s1_anchor_q <= q_anchor_i;
    end
    if (adv && s1_valid_q) begin
      s2_sgn_q    <= sgn_c;
      s2_zero_q   <= (s1_sum_q == '0);
      s2_mag_q    <= mag_c;
      s2_msb_q    <= msb_c;
      s2_anchor_q <= s1_anchor_q;
    end
    if (adv && s2_valid_q) begin
      result_q <= result_c;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign bf16_result_o = result_q;

endmodule

// ===== hw/rtl/anchored_fixed_point_dot_accumulate.sv =====
// Anchored fixed-point dot accumulator with bf16 output.
// Input channel (in_valid_i / in_stall_o): one request per cycle unless
// stalled. Opcode 0 carries an fp16 product, aligned to the anchor
// exponent and added to the running sum. Opcode 1 carries an e4m3 addend
// in bits 7:0; it is added, the sum is rounded to bf16, output and cleared.
// Output channel (out_valid_o / out_stall_i): one bf16 result per finish
// request, in order. Accumulate requests produce no output.
// Throughput: one request per cycle while in_stall_o is low. Alignment is
// combinational and the sum add is registered; a four-entry queue separates
// the aligner from the adder and the bf16 conversion pipeline.
// Path: a finish request passes through the queue, the finished-sum stage,
// the sign/leading-bit stage and the normalize/round stage to its result.
// Stall: while out_stall_i holds a result, the adder and conversion stages
// freeze; requests keep entering until the queue fills, then in_stall_o
// rises. The result and out_valid_o hold until taken.
// Reset: clears the running sum, the queue and all valid flags.
module anchored_fixed_point_dot_accumulate #(
  parameter int SUM_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [15:0] operand_bits_i,
  input  logic [7:0]  anchor_exponent_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] bf16_result_o
);

  logic                 push;
  afpda_pkg::op_e       push_op;
  logic [SUM_WIDTH-1:0] push_value;
  logic [7:0]           push_anchor;
  logic                 q_full;
  logic                 q_valid;
  logic                 pop;
  afpda_pkg::op_e       head_op;
  logic [SUM_WIDTH-1:0] head_value;
  logic [7:0]           head_anchor;

  afpda_front #(.SUM_WIDTH(SUM_WIDTH)) u_front (
    .in_valid_i        (in_valid_i),
    .opcode_i          (opcode_i),
    .operand_bits_i    (operand_bits_i),
    .anchor_exponent_i (anchor_exponent_i),
    .in_stall_o        (in_stall_o),
    .q_full_i          (q_full),
    .push_o            (push),
    .push_op_o         (push_op),
    .push_value_o      (push_value),
    .push_anchor_o     (push_anchor)
  );

  afpda_queue #(.SUM_WIDTH(SUM_WIDTH)) u_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .push_op_i     (push_op),
    .push_value_i  (push_value),
    .push_anchor_i (push_anchor),
    .full_o        (q_full),
    .pop_i         (pop),
    .valid_o       (q_valid),
    .head_op_o     (head_op),
    .head_value_o  (head_value),
    .head_anchor_o (head_anchor)
  );

  afpda_back #(.SUM_WIDTH(SUM_WIDTH)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_op_i        (head_op),
    .q_value_i     (head_value),
    .q_anchor_i    (head_anchor),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .bf16_result_o (bf16_result_o)
  );

endmodule

// ===== hw/rtl/afpda_props.sv =====
module afpda_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        opcode_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] bf16_result_o
);

  // queue entries plus two conversion stages plus the output slot
  localparam logic [3:0] MAX_PENDING = 4'd7;

  logic       finish_acc;
  logic       out_take;
  logic [3:0] pending_q, pending_d;

  assign finish_acc = in_valid_i && !in_stall_o && opcode_i;
  assign out_take   = out_valid_o && !out_stall_i;

  always_comb begin
    pending_d = pending_q;
    if (finish_acc && !out_take) begin
      pending_d = pending_q + 1'b1;
    end else if (out_take && !finish_acc) begin
      pending_d = pending_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(bf16_result_o))
    else $error("stalled result dropped or changed");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 4'd0)
    else $error("result without an outstanding finish request");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= MAX_PENDING)
    else $error("more finish requests outstanding than storage allows");

  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish_acc && pending_q == 4'd0 |=> !out_valid_o ##1 !out_valid_o)
    else $error("result appeared before the pipeline latency");

endmodule

bind anchored_fixed_point_dot_accumulate afpda_props u_props (.*);
